// ===== hdl/assert_macros.svh =====
// Assertion macros for the checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define DVC_ASSERT(lbl, clk, rst, prop) \
    lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
        else $error("assertion failed");
// Antecedent in one cycle implies the consequent in the next.
`define DVC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DVC_ASSERT(lbl, clk, rst, prop)
`define DVC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/dvc_pkg.sv =====
// Types and codes shared by the graph checker modules.
`default_nettype none
package dvc_pkg;
    localparam int ID_W        = 6;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_ADD_NODE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_EDGE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EVALUATE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_VALID    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP_EDGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP_NODE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RING     = 2'd3;

    typedef enum logic [1:0] {
        OP_NODE,
        OP_EDGE,
        OP_EVAL
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [ID_W-1:0] a;
        logic [ID_W-1:0] b;
    } t_op_item;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [COUNT_OUT_W-1:0] removed;
        logic [COUNT_OUT_W-1:0] distinct;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE,
        S_SCAN,
        S_POP,
        S_CUR,
        S_ROW,
        S_WALK,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

// ===== hdl/dvc_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module dvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== hdl/dvc_front.sv =====
// Front end: accept input words, classify commands, queue them for the engine.
`default_nettype none
module dvc_front #(
    parameter int NODES = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [dvc_pkg::CMD_W-1:0] i_cmd,
    input  wire logic [dvc_pkg::ID_W-1:0]  i_node_id,
    input  wire logic [dvc_pkg::ID_W-1:0]  i_src,
    input  wire logic [dvc_pkg::ID_W-1:0]  i_dst,
    output logic                           o_op_vld,
    input  wire logic                      i_op_rdy,
    output dvc_pkg::t_op_item              o_op
);
    import dvc_pkg::*;

    t_op_item             r_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wp, r_rp;
    logic [QUEUE_CW-1:0]  r_cnt;
    t_op_item             cls_item;
    logic                 cls_keep;
    logic                 push, pop;

    // Drop unused codes and identifiers beyond the node range.
    always_comb begin
        cls_item = '{op: OP_NODE, a: i_node_id, b: i_dst};
        cls_keep = 1'b0;
        unique case (i_cmd)
            CMD_ADD_NODE: begin
                cls_item.op = OP_NODE;
                cls_keep    = int'(i_node_id) < NODES;
            end
            CMD_ADD_EDGE: begin
                cls_item.op = OP_EDGE;
                cls_item.a  = i_src;
                cls_keep    = (int'(i_src) < NODES) && (int'(i_dst) < NODES);
            end
            CMD_EVALUATE: begin
                cls_item.op = OP_EVAL;
                cls_keep    = 1'b1;
            end
            default: begin
                cls_keep = 1'b0;
            end
        endcase
    end

    assign o_ready  = r_cnt != QUEUE_CW'(QUEUE_DEPTH);
    assign push     = i_valid && o_ready && cls_keep;
    assign o_op_vld = r_cnt != '0;
    assign pop      = o_op_vld && i_op_rdy;
    assign o_op     = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QUEUE_CW'(push) - QUEUE_CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls_item;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/dvc_engine.sv =====
// Back end: graph stores, edge updates and the Kahn walk sequencer.
`default_nettype none
`include "assert_macros.svh"
module dvc_engine #(
    parameter int NODES = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_op_vld,
    output logic               o_op_rdy,
    input  dvc_pkg::t_op_item  i_op,
    output logic               o_res_vld,
    input  wire logic          i_res_rdy,
    output dvc_pkg::t_result   o_res
);
    import dvc_pkg::*;

    localparam int IW = $clog2(NODES);
    localparam int XW = IW + 1;
    localparam int CW = $clog2(NODES + 1);

    t_state          r_state, n_state;
    logic [NODES-1:0] r_present, n_present;
    logic [NODES-1:0] r_adj_vld, n_adj_vld;
    logic [NODES-1:0] r_deg_vld, n_deg_vld;
    logic            r_dup_edge, n_dup_edge, r_dup_node, n_dup_node;
    logic [XW-1:0]   r_idx, n_idx, r_head, n_head, r_tail, n_tail;
    logic [IW-1:0]   r_pidx, n_pidx, r_a, n_a, r_b, n_b;
    logic            r_pvld, n_pvld;
    logic [CW-1:0]   r_removed, n_removed, r_distinct, n_distinct;
    logic [NODES-1:0] r_row, n_row;
    logic            r_out_vld, n_out_vld;
    t_result         r_out, n_out;

    logic            adj_we, adj_re, deg_we, deg_re, rq_we, rq_re;
    logic [IW-1:0]   adj_wa, adj_ra, deg_wa, deg_ra, rq_wa, rq_ra;
    logic [NODES-1:0] adj_wd, adj_rd, adj_eff;
    logic [CW-1:0]   deg_wd, deg_rd, deg_eff;
    logic [IW-1:0]   rq_wd, rq_rd;
    logic            idx_live, dup_any, out_free;

    dvc_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_adj (
        .i_clk(i_clk), .i_wr_en(adj_we), .i_wr_addr(adj_wa), .i_wr_data(adj_wd),
        .i_rd_en(adj_re), .i_rd_addr(adj_ra), .o_rd_data(adj_rd)
    );
    dvc_ram #(.WIDTH(CW), .DEPTH(NODES)) u_deg (
        .i_clk(i_clk), .i_wr_en(deg_we), .i_wr_addr(deg_wa), .i_wr_data(deg_wd),
        .i_rd_en(deg_re), .i_rd_addr(deg_ra), .o_rd_data(deg_rd)
    );
    dvc_ram #(.WIDTH(IW), .DEPTH(NODES)) u_rq (
        .i_clk(i_clk), .i_wr_en(rq_we), .i_wr_addr(rq_wa), .i_wr_data(rq_wd),
        .i_rd_en(rq_re), .i_rd_addr(rq_ra), .o_rd_data(rq_rd)
    );

    assign idx_live = r_idx < XW'(NODES);
    assign dup_any  = r_dup_edge || r_dup_node;
    assign out_free = !r_out_vld || i_res_rdy;
    // Rows and degrees never written since the last clear read as zero.
    assign adj_eff  = r_adj_vld[r_a] ? adj_rd : '0;
    assign deg_eff  = (r_state == S_EDGE ? r_deg_vld[r_b] : r_deg_vld[r_pidx])
                      ? deg_rd : '0;

    assign o_op_rdy  = r_state == S_IDLE;
    assign o_res_vld = r_out_vld;
    assign o_res     = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_op_vld) begin
                    unique case (i_op.op)
                        OP_EDGE: n_state = S_EDGE;
                        OP_EVAL: n_state = S_SCAN;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_EDGE: n_state = S_IDLE;
            S_SCAN: begin
                if (!idx_live && !r_pvld) begin
                    n_state = dup_any ? S_DONE : S_POP;
                end
            end
            S_POP:  n_state = (r_head < r_tail) ? S_CUR : S_DONE;
            S_CUR:  n_state = S_ROW;
            S_ROW:  n_state = S_WALK;
            S_WALK: begin
                if (!idx_live && !r_pvld) begin
                    n_state = S_POP;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_present  = r_present;
        n_adj_vld  = r_adj_vld;
        n_deg_vld  = r_deg_vld;
        n_dup_edge = r_dup_edge;
        n_dup_node = r_dup_node;
        n_idx      = r_idx;
        n_pidx     = r_pidx;
        n_pvld     = r_pvld;
        n_head     = r_head;
        n_tail     = r_tail;
        n_a        = r_a;
        n_b        = r_b;
        n_removed  = r_removed;
        n_distinct = r_distinct;
        n_row      = r_row;
        n_out_vld  = r_out_vld && !i_res_rdy;
        n_out      = r_out;
        adj_we = 1'b0; adj_wa = r_a;   adj_wd = adj_eff | (NODES'(1) << r_b);
        adj_re = 1'b0; adj_ra = r_a;
        deg_we = 1'b0; deg_wa = r_b;   deg_wd = CW'(deg_eff + 1'b1);
        deg_re = 1'b0; deg_ra = r_b;
        rq_we  = 1'b0; rq_wa  = r_tail[IW-1:0]; rq_wd = r_pidx;
        rq_re  = 1'b0; rq_ra  = r_head[IW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_op_vld) begin
                    unique case (i_op.op)
                        OP_NODE: begin
                            if (r_present[IW'(i_op.a)]) begin
                                n_dup_node = 1'b1;
                            end else begin
                                n_present[IW'(i_op.a)] = 1'b1;
                            end
                        end
                        OP_EDGE: begin
                            n_a    = IW'(i_op.a);
                            n_b    = IW'(i_op.b);
                            adj_re = 1'b1;
                            adj_ra = IW'(i_op.a);
                            deg_re = 1'b1;
                            deg_ra = IW'(i_op.b);
                        end
                        default: begin
                            n_idx      = '0;
                            n_pvld     = 1'b0;
                            n_head     = '0;
                            n_tail     = '0;
                            n_removed  = '0;
                            n_distinct = '0;
                        end
                    endcase
                end
            end
            S_EDGE: begin
                if (adj_eff[r_b]) begin
                    n_dup_edge = 1'b1;
                end else begin
                    adj_we         = 1'b1;
                    n_adj_vld[r_a] = 1'b1;
                    deg_we         = 1'b1;
                    n_deg_vld[r_b] = 1'b1;
                end
            end
            S_SCAN: begin
                // Issue one degree read per cycle, judge the previous node.
                deg_re = idx_live;
                deg_ra = r_idx[IW-1:0];
                n_pidx = r_idx[IW-1:0];
                n_pvld = idx_live;
                if (idx_live) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_pvld && r_present[r_pidx]) begin
                    n_distinct = r_distinct + 1'b1;
                    if (!dup_any && deg_eff == '0 && r_tail < XW'(NODES)) begin
                        rq_we  = 1'b1;
                        n_tail = r_tail + 1'b1;
                    end
                end
            end
            S_POP: begin
                if (r_head < r_tail) begin
                    rq_re  = 1'b1;
                    n_head = r_head + 1'b1;
                end
            end
            S_CUR: begin
                n_a       = rq_rd;
                adj_re    = 1'b1;
                adj_ra    = rq_rd;
                n_removed = r_removed + 1'b1;
            end
            S_ROW: begin
                n_row  = adj_eff;
                n_idx  = '0;
                n_pvld = 1'b0;
            end
            S_WALK: begin
                // Read degree of one node a cycle, write back the previous one if it is a target.
                deg_re = idx_live;
                deg_ra = r_idx[IW-1:0];
                n_pidx = r_idx[IW-1:0];
                n_pvld = idx_live;
                if (idx_live) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_pvld && r_row[r_pidx] && deg_eff != '0) begin
                    deg_we = 1'b1;
                    deg_wa = r_pidx;
                    deg_wd = deg_eff - 1'b1;
                    if (deg_eff == CW'(1) && r_tail < XW'(NODES)) begin
                        rq_we  = 1'b1;
                        n_tail = r_tail + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_vld        = 1'b1;
                    n_out.removed    = COUNT_OUT_W'(r_removed);
                    n_out.distinct   = COUNT_OUT_W'(r_distinct);
                    if (r_dup_edge) begin
                        n_out.status = ST_DUP_EDGE;
                    end else if (r_dup_node) begin
                        n_out.status = ST_DUP_NODE;
                    end else if (r_removed != r_distinct) begin
                        n_out.status = ST_RING;
                    end else begin
                        n_out.status = ST_VALID;
                    end
                    n_present  = '0;
                    n_adj_vld  = '0;
                    n_deg_vld  = '0;
                    n_dup_edge = 1'b0;
                    n_dup_node = 1'b0;
                end
            end
            default: begin
                n_pvld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_present  <= '0;
            r_adj_vld  <= '0;
            r_deg_vld  <= '0;
            r_dup_edge <= 1'b0;
            r_dup_node <= 1'b0;
            r_idx      <= '0;
            r_pvld     <= 1'b0;
            r_head     <= '0;
            r_tail     <= '0;
            r_removed  <= '0;
            r_distinct <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_present  <= n_present;
            r_adj_vld  <= n_adj_vld;
            r_deg_vld  <= n_deg_vld;
            r_dup_edge <= n_dup_edge;
            r_dup_node <= n_dup_node;
            r_idx      <= n_idx;
            r_pvld     <= n_pvld;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_removed  <= n_removed;
            r_distinct <= n_distinct;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= n_pidx;
        r_a    <= n_a;
        r_b    <= n_b;
        r_row  <= n_row;
        r_out  <= n_out;
    end

    `DVC_ASSERT(a_head_le_tail, i_clk, !i_rst_n, r_head <= r_tail)
    `DVC_ASSERT(a_tail_bound, i_clk, !i_rst_n, r_tail <= XW'(NODES))
    `DVC_ASSERT_NEXT(a_done_loads, i_clk, !i_rst_n,
        r_state == S_DONE && out_free, r_out_vld && r_present == '0)
endmodule
`default_nettype wire

// ===== hdl/dag_validity_checker.sv =====
// Add-node is taken in the engine idle state; add-edge passes through the edge state.
// Words queue at 1 word per cycle while the queue is not full. Evaluate: accept, scan
// all nodes, pop/cur/row/walk per removed node, a final pop, then load the result.
// Throughput: one command at a time in the engine; a 4-word queue fronts it.
// Reset: synchronous, active low; stores clear at once through valid bits.
`default_nettype none
module dag_validity_checker #(
    parameter int NODES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // node_id [5:0], edge_source [11:6], edge_target [17:12], zero pad
    input  wire logic [23:0] i_s_axis_tdata,
    // command [1:0]
    input  wire logic [1:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // removed_count [6:0], distinct_nodes [13:7], zero pad
    output logic [15:0]      o_m_axis_tdata,
    // status [1:0]
    output logic [1:0]       o_m_axis_tuser
);
    import dvc_pkg::*;

    logic     op_vld, op_rdy;
    t_op_item op;
    t_result  res;

    // Front: classify words and drop unused codes.
    dvc_front #(.NODES(NODES)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_cmd     (i_s_axis_tuser),
        .i_node_id (i_s_axis_tdata[5:0]),
        .i_src     (i_s_axis_tdata[11:6]),
        .i_dst     (i_s_axis_tdata[17:12]),
        .o_op_vld  (op_vld),
        .i_op_rdy  (op_rdy),
        .o_op      (op)
    );

    // Back: hold the graph and run the walk on evaluate.
    dvc_engine #(.NODES(NODES)) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op_vld  (op_vld),
        .o_op_rdy  (op_rdy),
        .i_op      (op),
        .o_res_vld (o_m_axis_tvalid),
        .i_res_rdy (i_m_axis_tready),
        .o_res     (res)
    );

    assign o_m_axis_tdata = {2'b00, res.distinct, res.removed};
    assign o_m_axis_tuser = res.status;
endmodule
`default_nettype wire
